// ----- rtl/core/cfit_pkg.sv -----
`default_nettype none

package cfit_pkg;

  localparam int unsigned ID_W      = 29;
  localparam int unsigned LEN_W     = 7;
  localparam int unsigned PAY_W     = 64;
  localparam int unsigned TIME_W    = 63;
  localparam int unsigned COUNT_W   = 32;
  localparam int unsigned SLOT_W    = 4;
  localparam int unsigned STATUS_W  = 2;
  localparam int unsigned PAY_BYTES = 8;

  // Command codes carried by an input item.
  localparam logic CMD_UPDATE = 1'b0;
  localparam logic CMD_DUMP   = 1'b1;

  // Result kinds.
  localparam logic KIND_STATUS = 1'b0;
  localparam logic KIND_ENTRY  = 1'b1;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_UPDATED  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_INSERTED = 2'd1;
  localparam logic [STATUS_W-1:0] ST_DROPPED  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_DUMP     = 2'd3;

  // One slot of the table as it is held in the slot memory.
  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic [LEN_W-1:0]   length;
    logic [PAY_W-1:0]   payload;
    logic [TIME_W-1:0]  rx_time;
    logic [COUNT_W-1:0] count;
  } slot_rec_t;

  // Byte enables for the first min(len, 8) payload bytes.
  function automatic logic [PAY_W-1:0] byte_mask(input logic [LEN_W-1:0] len);
    logic [PAY_W-1:0] m;
    m = '0;
    for (int b = 0; b < PAY_BYTES; b++) begin
      m[8*b +: 8] = {8{len > LEN_W'(b)}};
    end
    return m;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/can_frame_id_table.sv -----
// CAN receive message table with one slot per identifier.
// Input channel (in_*): valid/ready. in_cmd selects an update with a received
// frame or a dump of all used slots. The block takes one item at a time and
// holds in_ready low from acceptance until the item's work is finished.
// Output channel (out_*): valid/ready, fed from an output register. An update
// yields exactly one status item with out_last set. A dump yields one entry
// item per used slot in index order, out_last on the final one, and nothing
// when the table is empty.
// An update scans the slot memory one slot per cycle through its single
// registered read port. A hit ends the scan, and the status item then waits
// in the result state until the output register is free. An insert or a drop
// checks every slot first; an insert claims the lowest free slot. A dump
// visits each slot through a read state and then a check state, again set by
// the registered read of the slot memory, and stops after the last used slot.
// Reset clears the used bits, the sequencer and the output valid; the slot
// memory itself is not cleared, since a slot is always fully written when it
// is claimed. When the receiver stalls, the pending item stays in the output
// register and the sequencer waits before loading the next item.
`default_nettype none

module can_frame_id_table import cfit_pkg::*; #(
  parameter int unsigned TABLE_SLOTS = 16
) (
  input  wire logic                clk,
  input  wire logic                rst_n,

  input  wire logic                in_valid,
  output      logic                in_ready,
  input  wire logic                in_cmd,
  input  wire logic [ID_W-1:0]     in_frame_id,
  input  wire logic [LEN_W-1:0]    in_frame_length,
  input  wire logic [PAY_W-1:0]    in_payload,
  input  wire logic [TIME_W-1:0]   in_rx_time,

  output      logic                out_valid,
  input  wire logic                out_ready,
  output      logic                out_kind,
  output      logic [STATUS_W-1:0] out_status,
  output      logic [SLOT_W-1:0]   out_slot,
  output      logic [ID_W-1:0]     out_entry_id,
  output      logic [LEN_W-1:0]    out_entry_length,
  output      logic [PAY_W-1:0]    out_entry_payload,
  output      logic [TIME_W-1:0]   out_entry_time,
  output      logic [COUNT_W-1:0]  out_entry_count,
  output      logic                out_last
);

  // Slot index width; at least one bit so that a one-slot table still builds.
  localparam int unsigned IW = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_SLOTS - 1);

  typedef enum logic [4:0] {
    S_IDLE     = 5'b00001,
    S_SCAN     = 5'b00010,
    S_RESULT   = 5'b00100,
    S_DUMP_RD  = 5'b01000,
    S_DUMP_CHK = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  // Latched input item.
  logic [ID_W-1:0]   id_r;
  logic [LEN_W-1:0]  len_r;
  logic [PAY_W-1:0]  pay_r;
  logic [TIME_W-1:0] time_r;

  // Scan control.
  logic [IW-1:0] scan_idx_r, scan_idx_nxt;
  logic          issue_done_r, issue_done_nxt;
  logic          chk_vld_r, chk_vld_nxt;
  logic [IW-1:0] chk_idx_r, chk_idx_nxt;
  logic          free_vld_r, free_vld_nxt;
  logic [IW-1:0] free_idx_r, free_idx_nxt;

  logic [TABLE_SLOTS-1:0] used_r, used_nxt;
  logic [TABLE_SLOTS-1:0] dump_pend_r, dump_pend_nxt;
  logic [TABLE_SLOTS-1:0] pend_rest;

  // Update status waiting for the output register.
  logic [STATUS_W-1:0] res_status_r, res_status_nxt;
  logic [IW-1:0]       res_slot_r, res_slot_nxt;

  // Slot memory and merge unit.
  logic          mem_we;
  logic [IW-1:0] mem_waddr;
  slot_rec_t     mem_rdata;
  slot_rec_t     merge_rec;
  logic          hit;
  logic          chk_free;
  logic          chk_final;

  // Output register.
  logic                out_valid_r, out_valid_nxt;
  logic                out_load;
  logic                out_free;
  logic                out_kind_r, out_kind_nxt;
  logic [STATUS_W-1:0] out_status_r, out_status_nxt;
  logic [SLOT_W-1:0]   out_slot_r, out_slot_nxt;
  slot_rec_t           out_rec_r, out_rec_nxt;
  logic                out_last_r, out_last_nxt;

  logic in_acc;

  cfit_slot_mem #(
    .DEPTH (TABLE_SLOTS),
    .AW    (IW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (merge_rec),
    .rd_addr (scan_idx_r),
    .rd_data (mem_rdata)
  );

  cfit_merge u_merge (
    .old_rec      (mem_rdata),
    .use_old      (hit),
    .frame_id     (id_r),
    .frame_length (len_r),
    .payload      (pay_r),
    .rx_time      (time_r),
    .new_rec      (merge_rec)
  );

  assign in_ready = (state_r == S_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  // The check stage sees the slot that was addressed in the previous cycle.
  assign hit       = chk_vld_r && used_r[chk_idx_r] && (mem_rdata.id == id_r);
  assign chk_free  = chk_vld_r && !used_r[chk_idx_r];
  assign chk_final = chk_vld_r && (chk_idx_r == LAST_IDX);

  always_comb begin
    pend_rest             = dump_pend_r;
    pend_rest[scan_idx_r] = 1'b0;
  end

  always_comb begin
    state_nxt      = state_r;
    scan_idx_nxt   = scan_idx_r;
    issue_done_nxt = issue_done_r;
    chk_vld_nxt    = 1'b0;
    chk_idx_nxt    = chk_idx_r;
    free_vld_nxt   = free_vld_r;
    free_idx_nxt   = free_idx_r;
    used_nxt       = used_r;
    dump_pend_nxt  = dump_pend_r;
    res_status_nxt = res_status_r;
    res_slot_nxt   = res_slot_r;
    mem_we         = 1'b0;
    mem_waddr      = chk_idx_r;
    out_load       = 1'b0;
    out_kind_nxt   = KIND_STATUS;
    out_status_nxt = res_status_r;
    out_slot_nxt   = SLOT_W'(res_slot_r);
    out_rec_nxt    = '0;
    out_last_nxt   = 1'b1;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          scan_idx_nxt = '0;
          if (in_cmd == CMD_UPDATE) begin
            issue_done_nxt = 1'b0;
            free_vld_nxt   = 1'b0;
            state_nxt      = S_SCAN;
          end else begin
            dump_pend_nxt = used_r;
            if (used_r != '0) begin
              state_nxt = S_DUMP_RD;
            end
          end
        end
      end

      S_SCAN: begin
        if (hit) begin
          mem_we         = 1'b1;
          mem_waddr      = chk_idx_r;
          res_status_nxt = ST_UPDATED;
          res_slot_nxt   = chk_idx_r;
          state_nxt      = S_RESULT;
        end else if (chk_final) begin
          if (free_vld_r || chk_free) begin
            mem_we              = 1'b1;
            mem_waddr           = free_vld_r ? free_idx_r : chk_idx_r;
            used_nxt[mem_waddr] = 1'b1;
            res_status_nxt      = ST_INSERTED;
            res_slot_nxt        = mem_waddr;
          end else begin
            res_status_nxt = ST_DROPPED;
            res_slot_nxt   = '0;
          end
          state_nxt = S_RESULT;
        end else begin
          if (chk_free && !free_vld_r) begin
            free_vld_nxt = 1'b1;
            free_idx_nxt = chk_idx_r;
          end
          if (!issue_done_r) begin
            chk_vld_nxt = 1'b1;
            chk_idx_nxt = scan_idx_r;
            if (scan_idx_r == LAST_IDX) begin
              issue_done_nxt = 1'b1;
            end else begin
              scan_idx_nxt = scan_idx_r + IW'(1);
            end
          end
        end
      end

      S_RESULT: begin
        if (out_free) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      S_DUMP_RD: begin
        state_nxt = S_DUMP_CHK;
      end

      S_DUMP_CHK: begin
        if (dump_pend_r[scan_idx_r]) begin
          if (out_free) begin
            out_load       = 1'b1;
            out_kind_nxt   = KIND_ENTRY;
            out_status_nxt = ST_DUMP;
            out_slot_nxt   = SLOT_W'(scan_idx_r);
            out_rec_nxt    = mem_rdata;
            out_last_nxt   = (pend_rest == '0);
            dump_pend_nxt  = pend_rest;
            if (pend_rest == '0) begin
              state_nxt = S_IDLE;
            end else begin
              scan_idx_nxt = scan_idx_r + IW'(1);
              state_nxt    = S_DUMP_RD;
            end
          end
        end else begin
          scan_idx_nxt = scan_idx_r + IW'(1);
          state_nxt    = S_DUMP_RD;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r && !out_ready;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      scan_idx_r   <= '0;
      issue_done_r <= 1'b0;
      chk_vld_r    <= 1'b0;
      chk_idx_r    <= '0;
      free_vld_r   <= 1'b0;
      free_idx_r   <= '0;
      used_r       <= '0;
      dump_pend_r  <= '0;
      res_status_r <= ST_UPDATED;
      res_slot_r   <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      scan_idx_r   <= scan_idx_nxt;
      issue_done_r <= issue_done_nxt;
      chk_vld_r    <= chk_vld_nxt;
      chk_idx_r    <= chk_idx_nxt;
      free_vld_r   <= free_vld_nxt;
      free_idx_r   <= free_idx_nxt;
      used_r       <= used_nxt;
      dump_pend_r  <= dump_pend_nxt;
      res_status_r <= res_status_nxt;
      res_slot_r   <= res_slot_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      id_r   <= in_frame_id;
      len_r  <= in_frame_length;
      pay_r  <= in_payload;
      time_r <= in_rx_time;
    end
    if (out_load) begin
      out_kind_r   <= out_kind_nxt;
      out_status_r <= out_status_nxt;
      out_slot_r   <= out_slot_nxt;
      out_rec_r    <= out_rec_nxt;
      out_last_r   <= out_last_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_kind          = out_kind_r;
  assign out_status        = out_status_r;
  assign out_slot          = out_slot_r;
  assign out_entry_id      = out_rec_r.id;
  assign out_entry_length  = out_rec_r.length;
  assign out_entry_payload = out_rec_r.payload;
  assign out_entry_time    = out_rec_r.rx_time;
  assign out_entry_count   = out_rec_r.count;
  assign out_last          = out_last_r;

  // The check stage never carries a slot once the sequencer is back to idle.
  a_idle_no_check: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !chk_vld_r)
    else $error("check stage busy while idle");

  // The slot memory is written only while an update scans the table.
  a_write_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r == S_SCAN))
    else $error("slot memory written outside an update scan");

  // A claimed slot must have been free.
  a_claim_free: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_we && !hit) |-> !used_r[mem_waddr])
    else $error("claimed a slot that is already used");

  // Every write leaves its slot marked as used.
  a_write_marks_used: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |=> used_r[$past(mem_waddr)])
    else $error("written slot not marked used");

  // Slots still to be dumped are always used slots.
  a_pend_subset: assert property (@(posedge clk) disable iff (!rst_n)
    (dump_pend_r & ~used_r) == '0)
    else $error("dump pending on an unused slot");

endmodule

`default_nettype wire

// ----- rtl/core/cfit_slot_mem.sv -----
`default_nettype none

module cfit_slot_mem import cfit_pkg::*; #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = 4
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire slot_rec_t     wr_data,
  input  wire logic [AW-1:0] rd_addr,
  output      slot_rec_t     rd_data
);

  slot_rec_t mem [DEPTH];
  slot_rec_t rd_data_r;

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// ----- rtl/core/cfit_merge.sv -----
`default_nettype none

module cfit_merge import cfit_pkg::*; (
  input  wire slot_rec_t          old_rec,
  input  wire logic               use_old,
  input  wire logic [ID_W-1:0]    frame_id,
  input  wire logic [LEN_W-1:0]   frame_length,
  input  wire logic [PAY_W-1:0]   payload,
  input  wire logic [TIME_W-1:0]  rx_time,
  output      slot_rec_t          new_rec
);

  logic [PAY_W-1:0] mask;
  logic [PAY_W-1:0] base;

  // A hit keeps the bytes beyond the frame length; a new slot starts from zero.
  always_comb begin
    mask            = byte_mask(frame_length);
    base            = use_old ? old_rec.payload : '0;
    new_rec.id      = frame_id;
    new_rec.length  = frame_length;
    new_rec.payload = (base & ~mask) | (payload & mask);
    new_rec.rx_time = rx_time;
    new_rec.count   = use_old ? old_rec.count + COUNT_W'(1) : COUNT_W'(1);
  end

endmodule

`default_nettype wire

// ----- bench/tb_can_frame_id_table.sv -----
`default_nettype none

module tb_can_frame_id_table;
  timeunit 1ns;
  timeprecision 1ps;

  import cfit_pkg::*;

  localparam int SLOTS           = 16;
  localparam int ITEMS_PER_PHASE = 62;
  localparam int HOLD_CYCLES     = 300;
  // An update scans every slot and a full dump visits all 16 slots, so this quiet
  // drain is well beyond any result still in flight.
  localparam int DRAIN_CYCLES    = 100;

  localparam logic [ID_W-1:0] ID_MAX  = '1;
  localparam logic [ID_W-1:0] DROP_ID = ID_MAX - 1'b1;

  // A row either trusts the shadow table for its results, or carries the status
  // and slot of its update typed in by hand. A hand-checked dump row means that
  // the dump must produce nothing at all.
  typedef enum logic {CHECK_MODEL, CHECK_TYPED} check_t;

  typedef struct packed {
    logic                cmd;
    logic [ID_W-1:0]     id;
    logic [LEN_W-1:0]    len;
    logic [PAY_W-1:0]    pay;
    logic [TIME_W-1:0]   rx_time;
    check_t              mode;
    logic [STATUS_W-1:0] exp_status;
    logic [SLOT_W-1:0]   exp_slot;
  } frame_item_t;

  typedef struct packed {
    logic                kind;
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot;
    logic [ID_W-1:0]     entry_id;
    logic [LEN_W-1:0]    entry_length;
    logic [PAY_W-1:0]    entry_payload;
    logic [TIME_W-1:0]   entry_time;
    logic [COUNT_W-1:0]  entry_count;
    logic                last;
  } table_result_t;

  string field_names [9] = '{"kind", "status", "slot", "entry_id", "entry_length",
                             "entry_payload", "entry_time", "entry_count", "last"};

  // Clock, reset and the block's inputs, all known from time zero.
  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                in_valid        = 1'b0;
  logic                in_cmd          = CMD_UPDATE;
  logic [ID_W-1:0]     in_frame_id     = '0;
  logic [LEN_W-1:0]    in_frame_length = '0;
  logic [PAY_W-1:0]    in_payload      = '0;
  logic [TIME_W-1:0]   in_rx_time      = '0;
  logic                out_ready       = 1'b0;

  logic                in_ready;
  logic                out_valid;
  logic                out_kind;
  logic [STATUS_W-1:0] out_status;
  logic [SLOT_W-1:0]   out_slot;
  logic [ID_W-1:0]     out_entry_id;
  logic [LEN_W-1:0]    out_entry_length;
  logic [PAY_W-1:0]    out_entry_payload;
  logic [TIME_W-1:0]   out_entry_time;
  logic [COUNT_W-1:0]  out_entry_count;
  logic                out_last;

  // The item on the input port right now, with its checking mode attached.
  frame_item_t cur_item = '0;

  // Shadow copy of the slot table, advanced once per accepted item.
  bit                 shadow_used  [SLOTS];
  logic [ID_W-1:0]    shadow_id    [SLOTS];
  logic [LEN_W-1:0]   shadow_len   [SLOTS];
  logic [PAY_W-1:0]   shadow_pay   [SLOTS];
  logic [TIME_W-1:0]  shadow_time  [SLOTS];
  logic [COUNT_W-1:0] shadow_count [SLOTS];

  table_result_t shadow_results [$];   // results of the item just applied
  table_result_t pending_results [$];  // results still owed by the block

  frame_item_t       directed_frames [$];
  logic [ID_W-1:0]   known_ids [$];

  int mismatches    = 0;
  int results_seen  = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_left     = 0;
  bit stall_request = 1'b0;

  always #2 clk = ~clk;

  can_frame_id_table #(.TABLE_SLOTS(SLOTS)) i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_cmd            (in_cmd),
    .in_frame_id       (in_frame_id),
    .in_frame_length   (in_frame_length),
    .in_payload        (in_payload),
    .in_rx_time        (in_rx_time),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_kind          (out_kind),
    .out_status        (out_status),
    .out_slot          (out_slot),
    .out_entry_id      (out_entry_id),
    .out_entry_length  (out_entry_length),
    .out_entry_payload (out_entry_payload),
    .out_entry_time    (out_entry_time),
    .out_entry_count   (out_entry_count),
    .out_last          (out_last)
  );

  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("MISMATCH at %0t ns: %s", $time, msg);
  endtask

  function automatic logic [63:0] rnd64();
    return {$urandom(), $urandom()};
  endfunction

  // Applies one item to the shadow table and collects the results it causes.
  // An update hits the used slot holding its identifier, else claims the lowest
  // free slot, else is dropped. A dump lists every used slot in index order.
  task automatic shadow_apply(input frame_item_t it);
    logic [PAY_W-1:0] keep;
    int hit;
    int free_slot;
    int final_slot;
    table_result_t r;
    shadow_results.delete();
    r = '0;
    if (it.cmd == CMD_UPDATE) begin
      // Only the first min(length, 8) bytes of the payload are taken over.
      keep = (it.len >= PAY_BYTES) ? '1 : ((64'd1 << (8 * it.len)) - 64'd1);
      hit = -1;
      free_slot = -1;
      for (int s = 0; s < SLOTS; s++) begin
        if (shadow_used[s]) begin
          if (shadow_id[s] == it.id && hit < 0) hit = s;
        end else if (free_slot < 0) begin
          free_slot = s;
        end
      end
      r.kind = KIND_STATUS;
      r.last = 1'b1;
      if (hit >= 0) begin
        // Bytes at and above a short length keep what the slot held before.
        shadow_len[hit]   = it.len;
        shadow_pay[hit]   = (shadow_pay[hit] & ~keep) | (it.pay & keep);
        shadow_time[hit]  = it.rx_time;
        shadow_count[hit] = shadow_count[hit] + 1'b1;
        r.status = ST_UPDATED;
        r.slot   = SLOT_W'(hit);
      end else if (free_slot >= 0) begin
        // A fresh slot starts with zeros above a short length.
        shadow_used[free_slot]  = 1'b1;
        shadow_id[free_slot]    = it.id;
        shadow_len[free_slot]   = it.len;
        shadow_pay[free_slot]   = it.pay & keep;
        shadow_time[free_slot]  = it.rx_time;
        shadow_count[free_slot] = COUNT_W'(1);
        r.status = ST_INSERTED;
        r.slot   = SLOT_W'(free_slot);
      end else begin
        r.status = ST_DROPPED;
        r.slot   = '0;
      end
      shadow_results.push_back(r);
    end else begin
      final_slot = -1;
      for (int s = 0; s < SLOTS; s++) begin
        if (shadow_used[s]) final_slot = s;
      end
      for (int s = 0; s < SLOTS; s++) begin
        if (shadow_used[s]) begin
          r.kind          = KIND_ENTRY;
          r.status        = ST_DUMP;
          r.slot          = SLOT_W'(s);
          r.entry_id      = shadow_id[s];
          r.entry_length  = shadow_len[s];
          r.entry_payload = shadow_pay[s];
          r.entry_time    = shadow_time[s];
          r.entry_count   = shadow_count[s];
          r.last          = (s == final_slot);
          shadow_results.push_back(r);
        end
      end
    end
  endtask

  // Called at the edge where an item is taken. The payload is read from the
  // ports, so the prediction follows exactly what the block saw.
  task automatic predict_accepted();
    frame_item_t it;
    table_result_t r;
    it         = cur_item;
    it.cmd     = in_cmd;
    it.id      = in_frame_id;
    it.len     = in_frame_length;
    it.pay     = in_payload;
    it.rx_time = in_rx_time;
    shadow_apply(it);
    if (it.mode == CHECK_MODEL) begin
      foreach (shadow_results[k]) pending_results.push_back(shadow_results[k]);
    end else if (it.cmd == CMD_UPDATE) begin
      r        = '0;
      r.kind   = KIND_STATUS;
      r.status = it.exp_status;
      r.slot   = it.exp_slot;
      r.last   = 1'b1;
      pending_results.push_back(r);
    end
  endtask

  // Compares the result on the output port with the oldest one still owed.
  task automatic check_output();
    table_result_t got;
    table_result_t want;
    logic [63:0] g [9];
    logic [63:0] w [9];
    got.kind          = out_kind;
    got.status        = out_status;
    got.slot          = out_slot;
    got.entry_id      = out_entry_id;
    got.entry_length  = out_entry_length;
    got.entry_payload = out_entry_payload;
    got.entry_time    = out_entry_time;
    got.entry_count   = out_entry_count;
    got.last          = out_last;
    results_seen++;
    if (pending_results.size() == 0) begin
      report_mismatch($sformatf("result %0d arrived with nothing expected", results_seen));
    end else begin
      want = pending_results.pop_front();
      g = '{64'(got.kind), 64'(got.status), 64'(got.slot), 64'(got.entry_id),
            64'(got.entry_length), 64'(got.entry_payload), 64'(got.entry_time),
            64'(got.entry_count), 64'(got.last)};
      w = '{64'(want.kind), 64'(want.status), 64'(want.slot), 64'(want.entry_id),
            64'(want.entry_length), 64'(want.entry_payload), 64'(want.entry_time),
            64'(want.entry_count), 64'(want.last)};
      for (int f = 0; f < 9; f++) begin
        if (g[f] !== w[f]) begin
          report_mismatch($sformatf("result %0d %s: got %0h, expected %0h",
                                    results_seen, field_names[f], g[f], w[f]));
        end
      end
    end
  endtask

  // Both handshakes are sampled at the rising edge. Inputs move only at the
  // falling edge, so nothing here depends on event order within a step.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) predict_accepted();
      if (out_valid && out_ready) check_output();
    end
  end

  // Receiver. A stall request from the stimulus turns into a long hold-off,
  // counted here, during which the sender keeps offering items. The block then
  // fills its output register and has to hold its input off.
  always @(negedge clk) begin
    if (stall_request) begin
      stall_request = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic add_frame(input logic cmd, input logic [ID_W-1:0] id,
                           input logic [LEN_W-1:0] len, input logic [PAY_W-1:0] pay,
                           input logic [TIME_W-1:0] rx_time, input check_t mode,
                           input logic [STATUS_W-1:0] exp_status,
                           input logic [SLOT_W-1:0] exp_slot);
    frame_item_t it;
    it.cmd        = cmd;
    it.id         = id;
    it.len        = len;
    it.pay        = pay;
    it.rx_time    = rx_time;
    it.mode       = mode;
    it.exp_status = exp_status;
    it.exp_slot   = exp_slot;
    directed_frames.push_back(it);
  endtask

  // An identifier that no directed row uses yet.
  function automatic logic [ID_W-1:0] fresh_id();
    logic [ID_W-1:0] id;
    bit clash;
    do begin
      id = ID_W'($urandom());
      clash = 1'b0;
      foreach (known_ids[k]) if (known_ids[k] == id) clash = 1'b1;
    end while (clash);
    known_ids.push_back(id);
    return id;
  endfunction

  // The directed part walks the table from empty to full. The obvious rows
  // carry their status and slot by hand: an empty dump, inserts at the lowest
  // free slot, updates of a known identifier and a frame dropped by a full table.
  task automatic build_directed();
    known_ids = '{'0, ID_MAX, ID_W'(1), DROP_ID};
    // Dump of an empty table: nothing comes back.
    add_frame(CMD_DUMP, '0, '0, '0, '0, CHECK_TYPED, ST_DUMP, '0);
    // A zero-length frame claims slot 0 and keeps none of its payload.
    add_frame(CMD_UPDATE, '0, '0, '1, '0, CHECK_TYPED, ST_INSERTED, 4'd0);
    // Largest identifier and timestamp, with a length of 64, well above eight.
    add_frame(CMD_UPDATE, ID_MAX, 7'd64, '1, '1, CHECK_TYPED, ST_INSERTED, 4'd1);
    // Short frames on existing slots leave the upper bytes alone.
    add_frame(CMD_UPDATE, '0, 7'd3, 64'h0123_4567_89ab_cdef, 63'd1,
              CHECK_TYPED, ST_UPDATED, 4'd0);
    add_frame(CMD_UPDATE, ID_MAX, 7'd1, '0, '0, CHECK_TYPED, ST_UPDATED, 4'd1);
    // One bit away from slot 0's identifier must not hit it.
    add_frame(CMD_UPDATE, ID_W'(1), 7'd8, 64'h5555_5555_5555_5555,
              63'h2aaa_aaaa_aaaa_aaaa, CHECK_TYPED, ST_INSERTED, 4'd2);
    add_frame(CMD_DUMP, '0, '0, '0, '0, CHECK_MODEL, ST_DUMP, '0);
    // Fill the rest of the table with random content.
    for (int s = 3; s < SLOTS; s++) begin
      add_frame(CMD_UPDATE, fresh_id(), LEN_W'($urandom_range(64)), rnd64(),
                TIME_W'(rnd64()), CHECK_TYPED, ST_INSERTED, SLOT_W'(s));
    end
    // Full table: a new identifier is dropped, a known one still updates.
    add_frame(CMD_UPDATE, DROP_ID, 7'd8, rnd64(), TIME_W'(rnd64()),
              CHECK_TYPED, ST_DROPPED, 4'd0);
    add_frame(CMD_UPDATE, ID_MAX, 7'd9, rnd64(), TIME_W'(rnd64()),
              CHECK_MODEL, ST_UPDATED, '0);
    add_frame(CMD_DUMP, '0, '0, '0, '0, CHECK_MODEL, ST_DUMP, '0);
  endtask

  // Random items on the full table: mostly updates of stored identifiers,
  // some near misses and foreign identifiers that get dropped, and dumps.
  function automatic frame_item_t random_frame();
    frame_item_t it;
    int pick;
    int shape;
    it = '0;
    it.mode = CHECK_MODEL;
    pick = $urandom_range(99);
    it.cmd = (pick < 8) ? CMD_DUMP : CMD_UPDATE;
    if (pick < 70) begin
      it.id = shadow_id[$urandom_range(SLOTS - 1)];
    end else if (pick < 85) begin
      it.id = shadow_id[$urandom_range(SLOTS - 1)] ^ (ID_W'(1) << $urandom_range(ID_W - 1));
    end else begin
      it.id = ID_W'($urandom());
    end
    it.len = ($urandom_range(9) < 7) ? LEN_W'($urandom_range(8)) : LEN_W'($urandom_range(64));
    shape = $urandom_range(19);
    it.pay = (shape == 0) ? '0 : (shape == 1) ? '1 : rnd64();
    shape = $urandom_range(19);
    it.rx_time = (shape == 0) ? '0 : (shape == 1) ? '1 : TIME_W'(rnd64());
    return it;
  endfunction

  // Offers one item and returns at the edge where it is taken. The sender may
  // idle a random number of cycles first; valid then stays high and the
  // payload steady until the block takes the item.
  task automatic offer(input frame_item_t it);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid        <= 1'b1;
    in_cmd          <= it.cmd;
    in_frame_id     <= it.id;
    in_frame_length <= it.len;
    in_payload      <= it.pay;
    in_rx_time      <= it.rx_time;
    cur_item        <= it;
    do @(posedge clk); while (!(in_valid && in_ready));
  endtask

  initial begin
    build_directed();
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // Directed part and first random phase: the receiver is the slow side.
    send_idle_pct = 26;
    recv_idle_pct = 65;
    foreach (directed_frames[n]) offer(directed_frames[n]);

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 26;
          recv_idle_pct = 65;
        end
        1: begin
          // Now the sender is the slow side, and the receiver stalls hard once.
          send_idle_pct = 65;
          recv_idle_pct = 26;
          stall_request = 1'b1;
        end
        default: begin
          // Nobody idles, apart from one more long receiver stall while the
          // sender keeps pushing items back to back.
          send_idle_pct = 0;
          recv_idle_pct = 0;
          stall_request = 1'b1;
        end
      endcase
      repeat (ITEMS_PER_PHASE) offer(random_frame());
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // A correct run takes well under a tenth of this time.
  initial begin
    #2_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

`default_nettype wire

// ----- filelist.f -----
rtl/core/cfit_pkg.sv
rtl/core/cfit_slot_mem.sv
rtl/core/cfit_merge.sv
rtl/core/can_frame_id_table.sv
bench/tb_can_frame_id_table.sv
